// ===== rtl/sdlc_pkg.sv =====
// Package for the solenoid door lock controller.
// Word types, configuration types, register indexes, coil codes and reset values.
// No dependencies.
package sdlc_pkg;

    // Input word: one control tick of sensor and command bits
    typedef struct packed {
        logic raw_locked;
        logic raw_closed;
        logic coil_fault_in;
        logic power_enable;
        logic latch_enable;
        logic want_lock;
        logic force_unlock;
    } item_t;

    // Result word: status after the tick
    typedef struct packed {
        logic [1:0] door_state;
        logic [1:0] coil_drive;
        logic       coil_fault;
        logic       cooling_down;
    } result_t;

    // Configuration register file contents
    typedef struct packed {
        logic [7:0]  debounce_ticks;
        logic [9:0]  pulse_ticks;
        logic [11:0] cooldown_single_ticks;
        logic [12:0] cooldown_full_ticks;
        logic [2:0]  try_budget;
    } cfg_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE           = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_SINGLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_FULL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRY_BUDGET      = 3'd4;

    // Reset values of the registers
    localparam logic [7:0]  DEBOUNCE_RST        = 8'd10;
    localparam logic [9:0]  PULSE_RST           = 10'd100;
    localparam logic [11:0] COOLDOWN_SINGLE_RST = 12'd1328;
    localparam logic [12:0] COOLDOWN_FULL_RST   = 13'd2656;
    localparam logic [2:0]  TRY_BUDGET_RST      = 3'd2;

    // Coil command codes
    localparam logic [1:0] DRIVE_OFF    = 2'd0;
    localparam logic [1:0] DRIVE_LOCK   = 2'd1;
    localparam logic [1:0] DRIVE_UNLOCK = 2'd2;

    localparam logic [7:0] DEBOUNCE_MAX = 8'd255;

endpackage

// ===== rtl/sdlc_cfg.sv =====
// Configuration register file of the door lock controller.
// Depends on sdlc_pkg.
module sdlc_cfg
    import sdlc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // Write decode; indexes beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks        <= DEBOUNCE_RST;
            cfg_reg.pulse_ticks           <= PULSE_RST;
            cfg_reg.cooldown_single_ticks <= COOLDOWN_SINGLE_RST;
            cfg_reg.cooldown_full_ticks   <= COOLDOWN_FULL_RST;
            cfg_reg.try_budget            <= TRY_BUDGET_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE:        cfg_reg.debounce_ticks        <= cfg_data[7:0];
                REG_PULSE:           cfg_reg.pulse_ticks           <= cfg_data[9:0];
                REG_COOLDOWN_SINGLE: cfg_reg.cooldown_single_ticks <= cfg_data[11:0];
                REG_COOLDOWN_FULL:   cfg_reg.cooldown_full_ticks   <= cfg_data[12:0];
                REG_TRY_BUDGET:      cfg_reg.try_budget            <= cfg_data[2:0];
                default:             ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/sdlc_ctrl.sv =====
// Tick logic of the door lock controller: debouncer, pulse timers, retries,
// fault and cool-down, with the state registers. Depends on sdlc_pkg.
module sdlc_ctrl
    import sdlc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    step,
    input  item_t   item,
    output result_t result
);

    logic [1:0]  stable_door_reg, stable_door_next;
    logic [7:0]  debounce_count_reg, debounce_count_next;
    logic [9:0]  on_timer_reg, on_timer_next;
    logic [9:0]  off_timer_reg, off_timer_next;
    logic [12:0] cooldown_timer_reg, cooldown_timer_next;
    logic [2:0]  tries_left_reg, tries_left_next;
    logic        last_direction_reg, last_direction_next;
    logic        cooldown_done_reg, cooldown_done_next;
    logic        override_active_reg, override_active_next;
    logic [1:0]  drive_reg, drive_next;
    logic        fault_reg, fault_next;

    logic [1:0]  sample;
    logic [7:0]  count_inc;
    logic        dir;
    logic        locked;
    logic        halt;

    assign sample = {item.raw_closed, item.raw_locked};

    // Next state for one tick
    always_comb
    begin
        stable_door_next     = stable_door_reg;
        debounce_count_next  = debounce_count_reg;
        on_timer_next        = on_timer_reg;
        off_timer_next       = off_timer_reg;
        cooldown_timer_next  = cooldown_timer_reg;
        tries_left_next      = tries_left_reg;
        last_direction_next  = last_direction_reg;
        cooldown_done_next   = cooldown_done_reg;
        override_active_next = override_active_reg;
        drive_next           = drive_reg;
        fault_next           = fault_reg;
        dir                  = item.want_lock;
        halt                 = !item.power_enable;
        count_inc            = debounce_count_reg;

        // debouncer: count uses the incremented value before the compare
        if (stable_door_reg != sample)
        begin
            if (debounce_count_reg < DEBOUNCE_MAX)
                count_inc = debounce_count_reg + 8'd1;
            if (count_inc >= cfg.debounce_ticks)
            begin
                stable_door_next    = sample;
                debounce_count_next = '0;
            end
            else
                debounce_count_next = count_inc;
        end
        else
            debounce_count_next = '0;

        // override: unlock try from idle, else abort a pulse or its off time
        if (!halt && item.force_unlock)
        begin
            if (cooldown_timer_reg == '0 && on_timer_reg == '0 && off_timer_reg == '0)
            begin
                if (!override_active_reg && item.raw_locked)
                begin
                    tries_left_next      = 3'd1;
                    override_active_next = 1'b1;
                    dir                  = 1'b0;
                    last_direction_next  = 1'b0;
                end
                else
                    halt = 1'b1;
            end
            else if (!override_active_reg && cooldown_timer_reg == '0)
            begin
                drive_next          = DRIVE_OFF;
                on_timer_next       = '0;
                off_timer_next      = '0;
                cooldown_timer_next = {1'b0, cfg.cooldown_single_ticks};
                cooldown_done_next  = 1'b0;
            end
        end

        locked = stable_door_next[0];

        // pulse sequencing
        if (!halt)
        begin
            if (cooldown_timer_next != '0)
            begin
                cooldown_timer_next = cooldown_timer_next - 13'd1;
                if (cooldown_timer_next == '0)
                    cooldown_done_next = 1'b1;
            end
            else if (on_timer_next != '0)
            begin
                on_timer_next = on_timer_next - 10'd1;
                if (on_timer_next == '0 || dir == locked)
                begin
                    off_timer_next = cfg.pulse_ticks - on_timer_next;
                    on_timer_next  = '0;
                    drive_next     = DRIVE_OFF;
                end
                if (dir == locked)
                    cooldown_done_next = 1'b1;
            end
            else if (off_timer_next != '0)
                off_timer_next = off_timer_next - 10'd1;
            else if ((item.latch_enable || item.force_unlock) && dir != locked
                     && tries_left_next != '0)
            begin
                tries_left_next    = tries_left_next - 3'd1;
                on_timer_next      = cfg.pulse_ticks;
                drive_next         = dir ? DRIVE_LOCK : DRIVE_UNLOCK;
                fault_next         = item.coil_fault_in;
                cooldown_done_next = 1'b0;
            end
            else
            begin
                drive_next = DRIVE_OFF;
                if (tries_left_next == '0 && dir != locked)
                begin
                    fault_next = 1'b1;
                    if (!cooldown_done_next)
                        cooldown_timer_next = override_active_next
                            ? {1'b0, cfg.cooldown_single_ticks}
                            : cfg.cooldown_full_ticks;
                end
                else
                    fault_next = 1'b0;
                override_active_next = 1'b0;
            end

            // direction change reloads the retry budget
            if (dir != last_direction_next)
            begin
                last_direction_next = dir;
                tries_left_next     = cfg.try_budget;
            end
        end
    end

    // State registers, updated on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_door_reg     <= '0;
            debounce_count_reg  <= '0;
            on_timer_reg        <= '0;
            off_timer_reg       <= '0;
            cooldown_timer_reg  <= '0;
            tries_left_reg      <= TRY_BUDGET_RST;
            last_direction_reg  <= 1'b0;
            cooldown_done_reg   <= 1'b1;
            override_active_reg <= 1'b0;
            drive_reg           <= DRIVE_OFF;
            fault_reg           <= 1'b0;
        end
        else if (step)
        begin
            stable_door_reg     <= stable_door_next;
            debounce_count_reg  <= debounce_count_next;
            on_timer_reg        <= on_timer_next;
            off_timer_reg       <= off_timer_next;
            cooldown_timer_reg  <= cooldown_timer_next;
            tries_left_reg      <= tries_left_next;
            last_direction_reg  <= last_direction_next;
            cooldown_done_reg   <= cooldown_done_next;
            override_active_reg <= override_active_next;
            drive_reg           <= drive_next;
            fault_reg           <= fault_next;
        end
    end

    // Result word from the post-tick state
    assign result.door_state   = stable_door_next;
    assign result.coil_drive   = drive_next;
    assign result.coil_fault   = fault_next;
    assign result.cooling_down = (cooldown_timer_next != '0);

endmodule

// ===== rtl/sdlc_out_buf.sv =====
// Two-entry result buffer (output register plus skid stage).
// Depends on sdlc_pkg.
module sdlc_out_buf
    import sdlc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_word,
    output logic    full,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    take;

    assign take = main_valid_reg && !result_stall;

    // Buffer control
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = push_word;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_word;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full         = skid_valid_reg;
    assign result_valid = main_valid_reg;
    assign result       = main_reg;

endmodule

// ===== rtl/solenoid_door_lock_controller_unit.sv =====
// Top level of the solenoid door lock controller.
// Depends on sdlc_pkg, sdlc_cfg, sdlc_ctrl and sdlc_out_buf.
//
//  channel   handshake                      word
//  -------   ---------                      ----
//  item      item_valid / item_stall        item_t   (sensor and command bits)
//  result    result_valid / result_stall    result_t (door state, coil, status)
//  config    cfg_we, cfg_index              cfg_data (13 bit)
//
// One word per cycle while item_stall is low: the tick logic works directly on
// the accepted word and the state registers, and the result is registered.
// The two-entry result buffer keeps accepting while a result waits; item_stall
// rises only when both entries are held. Reset (rst_n, asynchronous) loads the
// register defaults and empties the buffer; no clearing pass is needed.
module solenoid_door_lock_controller_unit
    import sdlc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    result_t tick_word;
    logic    full;
    logic    push;

    assign item_stall = full;
    assign push       = item_valid && !full;

    sdlc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sdlc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (push),
        .item   (item),
        .result (tick_word)
    );

    sdlc_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_word    (tick_word),
        .full         (full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== rtl/sdlc_checker.sv =====
// Port-level checks for the door lock controller, bound to the top level.
// Depends on sdlc_pkg.
module sdlc_checker
    import sdlc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // A stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // Input only stalls when the output side holds a word
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("item stalled with empty output");

    // An accepted word always leaves a result pending next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> result_valid)
        else $error("accepted word produced no result");

    // The coil is only given one of the defined commands
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.coil_drive == DRIVE_OFF || result.coil_drive == DRIVE_LOCK
                          || result.coil_drive == DRIVE_UNLOCK))
        else $error("invalid coil command");

endmodule

bind solenoid_door_lock_controller_unit sdlc_checker u_sdlc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ===== dv/tb_solenoid_door_lock_controller_unit.sv =====
// Testbench for solenoid_door_lock_controller_unit: drives tick words with random idling and
// back-pressure, predicts each status word in a scoreboard class and checks every field.
// Depends on sdlc_pkg and the RTL of the controller.
module tb_solenoid_door_lock_controller_unit;
    import sdlc_pkg::*;

    // Scoreboard: its own copy of the registers and the lock state, plus the pending statuses
    class door_lock_scoreboard;
        logic [7:0]  debounce_ticks;
        logic [9:0]  pulse_ticks;
        logic [11:0] cool_single_ticks;
        logic [12:0] cool_full_ticks;
        logic [2:0]  try_budget;

        logic [1:0]  stable_door;
        logic [7:0]  bounce_count;
        logic [9:0]  on_left;
        logic [9:0]  off_left;
        logic [12:0] cool_left;
        logic [2:0]  tries_left;
        logic        last_dir;
        bit          cool_done;
        bit          override_on;
        logic [1:0]  drive;
        logic        fault;

        result_t     status_q[$];
        int unsigned mismatches;

        function new();
            debounce_ticks    = DEBOUNCE_RST;
            pulse_ticks       = PULSE_RST;
            cool_single_ticks = COOLDOWN_SINGLE_RST;
            cool_full_ticks   = COOLDOWN_FULL_RST;
            try_budget        = TRY_BUDGET_RST;
            stable_door       = 2'd0;
            bounce_count      = 8'd0;
            on_left           = 10'd0;
            off_left          = 10'd0;
            cool_left         = 13'd0;
            tries_left        = TRY_BUDGET_RST;
            last_dir          = 1'b0;
            cool_done         = 1'b1;
            override_on       = 1'b0;
            drive             = DRIVE_OFF;
            fault             = 1'b0;
            mismatches        = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DEBOUNCE:        debounce_ticks    = data[7:0];
                REG_PULSE:           pulse_ticks       = data[9:0];
                REG_COOLDOWN_SINGLE: cool_single_ticks = data[11:0];
                REG_COOLDOWN_FULL:   cool_full_ticks   = data[12:0];
                REG_TRY_BUDGET:      try_budget        = data[2:0];
                default: ;
            endcase
        endfunction

        // Advance the lock state by one tick and queue the status it leaves behind
        function void note_tick(item_t w);
            logic [1:0] sample;
            logic       dir;
            logic       locked;
            bit         held;
            result_t    st;
            sample = {w.raw_closed, w.raw_locked};
            dir    = w.want_lock;
            held   = 1'b0;

            // debouncer runs on every tick
            if (stable_door != sample)
            begin
                if (bounce_count < DEBOUNCE_MAX)
                    bounce_count++;
                if (bounce_count >= debounce_ticks)
                begin
                    stable_door  = sample;
                    bounce_count = 8'd0;
                end
            end
            else
            begin
                bounce_count = 8'd0;
            end

            if (!w.power_enable)
            begin
                held = 1'b1;
            end
            else if (w.force_unlock)
            begin
                if (cool_left == 0 && on_left == 0 && off_left == 0)
                begin
                    // override from idle: one unlock try, only if the raw sensor says locked
                    if (!override_on && w.raw_locked)
                    begin
                        tries_left  = 3'd1;
                        override_on = 1'b1;
                        dir         = 1'b0;
                        last_dir    = 1'b0;
                    end
                    else
                    begin
                        held = 1'b1;
                    end
                end
                else if (!override_on && cool_left == 0)
                begin
                    // abort the pulse or off time in progress
                    drive     = DRIVE_OFF;
                    on_left   = 10'd0;
                    off_left  = 10'd0;
                    cool_left = {1'b0, cool_single_ticks};
                    cool_done = 1'b0;
                end
            end

            if (!held)
            begin
                locked = stable_door[0];
                if (cool_left != 0)
                begin
                    cool_left--;
                    if (cool_left == 0)
                        cool_done = 1'b1;
                end
                else if (on_left != 0)
                begin
                    on_left--;
                    if (on_left == 0 || dir == locked)
                    begin
                        off_left = pulse_ticks - on_left;
                        on_left  = 10'd0;
                        drive    = DRIVE_OFF;
                    end
                    if (dir == locked)
                        cool_done = 1'b1;
                end
                else if (off_left != 0)
                begin
                    off_left--;
                end
                else if ((w.latch_enable || w.force_unlock) && dir != locked
                         && tries_left > 0)
                begin
                    tries_left--;
                    on_left   = pulse_ticks;
                    drive     = dir ? DRIVE_LOCK : DRIVE_UNLOCK;
                    fault     = w.coil_fault_in;
                    cool_done = 1'b0;
                end
                else
                begin
                    drive = DRIVE_OFF;
                    if (tries_left == 0 && dir != locked)
                    begin
                        fault = 1'b1;
                        if (!cool_done)
                            cool_left = override_on ? {1'b0, cool_single_ticks}
                                                    : cool_full_ticks;
                    end
                    else
                    begin
                        fault = 1'b0;
                    end
                    override_on = 1'b0;
                end

                // a new ordered direction reloads the tries
                if (dir != last_dir)
                begin
                    last_dir   = dir;
                    tries_left = try_budget;
                end
            end

            st.door_state   = stable_door;
            st.coil_drive   = drive;
            st.coil_fault   = fault;
            st.cooling_down = (cool_left != 0);
            status_q.push_back(st);
        endfunction

        task report_mismatch(string what, int got_v, int want_v);
            $display("mismatch: %s got %0d expected %0d (%0d pending)",
                     what, got_v, want_v, status_q.size());
            mismatches++;
        endtask

        task check_status(result_t got);
            result_t want;
            if (status_q.size() == 0)
            begin
                report_mismatch("status word with nothing pending", int'(got), 0);
                return;
            end
            want = status_q.pop_front();
            if (got.door_state !== want.door_state)
                report_mismatch("door_state", int'(got.door_state), int'(want.door_state));
            if (got.coil_drive !== want.coil_drive)
                report_mismatch("coil_drive", int'(got.coil_drive), int'(want.coil_drive));
            if (got.coil_fault !== want.coil_fault)
                report_mismatch("coil_fault", int'(got.coil_fault), int'(want.coil_fault));
            if (got.cooling_down !== want.cooling_down)
                report_mismatch("cooling_down", int'(got.cooling_down),
                                int'(want.cooling_down));
        endtask

        function int pending();
            return status_q.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_stall;
    item_t                 item;
    logic                  result_valid;
    logic                  result_stall;
    result_t               result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    door_lock_scoreboard sb = new();

    int unsigned sent_count    = 0;
    int unsigned checked_count = 0;

    // simple door model for the random words
    bit plant_locked = 1'b0;
    bit plant_closed = 1'b1;
    bit order_lock   = 1'b0;

    solenoid_door_lock_controller_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic item_t mk(bit rl, bit rc, bit fin, bit pwr, bit lat, bit want, bit frc);
        return item_t'({rl, rc, fin, pwr, lat, want, frc});
    endfunction

    // Mostly a door that follows the order with some lag; a tenth is pure noise
    function automatic item_t next_tick();
        item_t w;
        if ($urandom_range(99) < 10)
            return item_t'(7'($urandom_range(127)));
        if ($urandom_range(99) < 8)
            order_lock = !order_lock;
        if (plant_locked != order_lock && $urandom_range(99) < 25)
            plant_locked = order_lock;
        else if ($urandom_range(99) < 4)
            plant_locked = !plant_locked;
        if ($urandom_range(99) < 6)
            plant_closed = !plant_closed;
        w.raw_locked    = plant_locked;
        w.raw_closed    = plant_closed;
        w.coil_fault_in = ($urandom_range(99) < 10);
        w.power_enable  = ($urandom_range(99) < 92);
        w.latch_enable  = ($urandom_range(99) < 80);
        w.want_lock     = order_lock;
        w.force_unlock  = ($urandom_range(99) < 4);
        return w;
    endfunction

    // Entered and left at a falling edge; valid stays up into the next word
    task automatic send_word(item_t w);
        bit quiet;
        quiet = (sent_count >= 200 && sent_count < 280);
        while (!quiet && $urandom_range(99) < 37)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        forever
        begin
            @(posedge clk);
            if (!item_stall)
                break;
        end
        sb.note_tick(w);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[CFG_DATA_W-1:0];
        sb.write_reg(idx, data[CFG_DATA_W-1:0]);
    endtask

    task automatic program_regs(int unsigned deb, int unsigned pulse, int unsigned single,
                                int unsigned full, int unsigned tries);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_PULSE, pulse);
        write_reg(REG_COOLDOWN_SINGLE, single);
        write_reg(REG_COOLDOWN_FULL, full);
        write_reg(REG_TRY_BUDGET, tries);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stop offering and wait for every pending status word
    task automatic drain();
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Status receiver: random stalls, one long hold-off, one stretch with no stalls
    initial
    begin
        bit pressure_done;
        bit quiet;
        pressure_done = 1'b0;
        result_stall  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!pressure_done && checked_count == 120)
            begin
                pressure_done = 1'b1;
                result_stall <= 1'b1;
                repeat (60) @(negedge clk);
            end
            quiet = (checked_count >= 300 && checked_count < 380);
            result_stall <= !quiet && ($urandom_range(99) < 37);
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                sb.check_status(result);
                checked_count++;
            end
        end
    end

    // Main sequence
    initial
    begin
        item_t directed_q[$];
        int    p;
        int    n;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: override from idle, early pulse end, failed retries, abort, power off
        program_regs(0, 3, 5, 7, 2);
        directed_q.push_back(mk(0, 0, 0, 0, 0, 0, 0));
        directed_q.push_back(mk(1, 1, 1, 1, 1, 1, 1));
        directed_q.push_back(mk(1, 1, 0, 1, 1, 0, 0));
        directed_q.push_back(mk(0, 1, 0, 1, 1, 0, 0));
        directed_q.push_back(mk(0, 1, 0, 1, 1, 0, 0));
        directed_q.push_back(mk(0, 1, 0, 1, 1, 0, 0));
        for (n = 0; n < 10; n++)
            directed_q.push_back(mk(0, 1, n == 2, 1, 1, 1, 0));
        directed_q.push_back(mk(0, 1, 0, 1, 1, 1, 1));
        directed_q.push_back(mk(1, 0, 0, 0, 1, 1, 0));
        directed_q.push_back(mk(1, 0, 1, 1, 1, 1, 0));
        directed_q.push_back(mk(1, 0, 0, 1, 1, 0, 0));
        directed_q.push_back(mk(1, 0, 0, 1, 0, 0, 1));
        directed_q.push_back(mk(0, 1, 1, 1, 0, 1, 1));
        directed_q.push_back(mk(0, 0, 1, 0, 0, 0, 0));
        foreach (directed_q[i])
            send_word(directed_q[i]);
        drain();

        // Random phases: zero settings, low settings, then small random settings
        for (p = 0; p < 6; p++)
        begin
            if (p == 0)
                program_regs(0, 0, 0, 0, 0);
            else if (p == 1)
                program_regs(1, 1, 0, 0, 1);
            else
                program_regs($urandom_range(4), $urandom_range(12), $urandom_range(30),
                             $urandom_range(50), $urandom_range(7));
            for (n = 0; n < 60; n++)
                send_word(next_tick());
            drain();
        end

        // Largest settings last, as their cool-downs outlast the run
        program_regs(255, 1023, 4095, 8191, 7);
        for (n = 0; n < 60; n++)
            send_word(next_tick());
        drain();
        repeat (5) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("FAIL");
        $finish;
    end

endmodule
